### rtl/dual_temp_sensor_vote_fusion_core_assert.svh
// assertion macros for the sensor fusion core
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef DUAL_TEMP_SENSOR_VOTE_FUSION_CORE_ASSERT_SVH
`define DUAL_TEMP_SENSOR_VOTE_FUSION_CORE_ASSERT_SVH

// same-cycle implication
`define DTSVF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTSVF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtsvf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the sensor fusion core
// no dependencies
package dtsvf_pkg;

  localparam int unsigned Samples   = 8;
  localparam int unsigned SampleW   = $clog2(Samples);
  localparam int unsigned CountW    = $clog2(Samples + 1);
  localparam int unsigned SumW      = $clog2(Samples * 1023 + 1);

  localparam int unsigned CodeW     = 10;
  localparam int unsigned TempW     = 12;
  localparam int unsigned HumW      = 10;
  localparam int unsigned AtempW    = 10;
  localparam int unsigned LimitW    = 11;
  localparam int unsigned CauseW    = 2;

  // apb side
  localparam int unsigned PdataW    = 32;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned RegIdxW   = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegJumpLimit = '0;
  localparam logic [LimitW-1:0]  JumpLimitReset = LimitW'(30);

  // calibration: atemp = floor((K*sum + C) / D), rounding folded into C and D
  localparam longint unsigned DivNumK = 64'd1000000;
  localparam longint unsigned DivNumC = 64'd257433600 * Samples + 64'd1282048 * Samples;
  localparam longint unsigned DivDen  = 64'd2564096 * Samples;
  localparam int unsigned     DivKW   = $clog2(DivNumK + 1);
  localparam longint unsigned NumMax  = DivNumK * (Samples * 1023) + DivNumC;
  localparam int unsigned     NumW    = $clog2(NumMax + 1);
  localparam int unsigned     QuotW   = AtempW;

  // D = 313 * 2^13 * Samples: shift out 2^13, then multiply by a rounded-up
  // reciprocal of the rest (313 * Samples), exact for every scaled numerator
  localparam int unsigned     DivPow     = 13;
  localparam longint unsigned DivOdd     = DivDen >> DivPow;
  localparam int unsigned     ScaledW    = NumW - DivPow;
  localparam int unsigned     RecipShift = ScaledW + $clog2(DivOdd);
  localparam longint unsigned Recip      = ((64'd1 << RecipShift) + DivOdd - 64'd1) / DivOdd;
  localparam int unsigned     RecipW     = $clog2(Recip + 1);

  typedef enum logic [1:0] {
    CauseOk,
    CauseMissed,
    CauseNoMajority,
    CauseJump
  } cause_e;

  typedef enum logic [1:0] {
    StCollect,
    StDivide,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic                     done;
    logic [CountW-1:0]        best_n;
    logic signed [TempW-1:0]  temp;
    logic [HumW-1:0]          hum;
  } vote_res_t;

endpackage

### rtl/dtsvf_in_if.sv
`timescale 1ns / 1ps
// input channel: one sample set per item
// depends on dtsvf_pkg
interface dtsvf_in_if import dtsvf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CodeW-1:0]        analog_code;
  logic signed [TempW-1:0] digital_temp;
  logic [HumW-1:0]         digital_humidity;
  logic                    digital_valid;

  modport source (
    output valid, analog_code, digital_temp, digital_humidity, digital_valid,
    input  ready
  );
  modport sink (
    input  valid, analog_code, digital_temp, digital_humidity, digital_valid,
    output ready
  );
endinterface

### rtl/dtsvf_out_if.sv
`timescale 1ns / 1ps
// result channel: one fused reading per batch
// depends on dtsvf_pkg
interface dtsvf_out_if import dtsvf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] fused_temp;
  logic [AtempW-1:0]       analog_temp;
  logic signed [TempW-1:0] accepted_temp;
  logic [HumW-1:0]         accepted_humidity;
  logic                    digital_down;
  logic [CauseW-1:0]       fault_cause;

  modport source (
    output valid, fused_temp, analog_temp, accepted_temp, accepted_humidity,
    output digital_down, fault_cause,
    input  ready
  );
  modport sink (
    input  valid, fused_temp, analog_temp, accepted_temp, accepted_humidity,
    input  digital_down, fault_cause,
    output ready
  );
endinterface

### rtl/dual_temp_sensor_vote_fusion_core.sv
`timescale 1ns / 1ps
// top level of the dual sensor fusion core: sequencer, apb register, result register
// depends on dtsvf_pkg, dtsvf_in_if, dtsvf_out_if, dtsvf_store, dtsvf_div, dtsvf_vote
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------------
//  in_i     | in  | valid / ready   | analog_code, digital_temp, digital_humidity,
//           |     |                 | digital_valid
//  out_o    | out | valid / ready   | fused_temp, analog_temp, accepted_temp,
//           |     |                 | accepted_humidity, digital_down, fault_cause
//  apb      | in  | psel / penable  | paddr, pwdata, prdata (jump_limit at 0)
//
// a sample item that is not the last of its batch is taken as soon as it is valid
// when a sample was missed, ready stays low after the last item of a batch through the
// divider start, the two calibration multiplies, the decision and the result load
// with every sample valid the pairwise vote scan over every stored pair comes before
// the finish; a full result register stretches the finish
// the result register lets a new batch start while a result still waits
// reset clears counters, the accepted reading and jump_limit (to 30); no clear pass
`include "dual_temp_sensor_vote_fusion_core_assert.svh"
module dual_temp_sensor_vote_fusion_core import dtsvf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtsvf_in_if.sink          in_i,
  dtsvf_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  state_e                  state_q, state_d;
  logic [SampleW-1:0]      sample_cnt_q, sample_cnt_d;
  logic [CountW-1:0]       valid_cnt_q, valid_cnt_d;
  logic [SumW-1:0]         code_sum_q, code_sum_d;
  logic                    div_go_q, div_go_d;
  logic [LimitW-1:0]       jump_limit_q;
  logic signed [TempW-1:0] last_temp_q;
  logic [HumW-1:0]         last_hum_q;
  logic                    have_acc_q;

  logic                    out_valid_q;
  logic signed [TempW-1:0] out_fused_q;
  logic [AtempW-1:0]       out_atemp_q;
  logic signed [TempW-1:0] out_acc_temp_q;
  logic [HumW-1:0]         out_acc_hum_q;
  logic                    out_down_q;
  cause_e                  out_cause_q;

  logic in_ready, in_acc, last_sample, vote_start, out_load;
  logic cfg_wr, cfg_hit;

  div_stat_t                div_stat;
  logic [QuotW-1:0]         quot;
  vote_res_t                vote_res;
  logic [SampleW-1:0]       addr_a, addr_b;
  logic signed [TempW-1:0]  rtemp_a, rtemp_b;
  logic [HumW-1:0]          rhum_a;

  cause_e                   cause;
  logic                     missed, majority, jump;
  logic signed [TempW:0]    diff;
  logic [TempW:0]           abs_diff;
  logic signed [TempW:0]    fuse_sum;
  logic signed [TempW-1:0]  fused;
  logic signed [TempW-1:0]  new_temp;
  logic [HumW-1:0]          new_hum;

  // configuration register
  assign pready  = 1'b1;
  assign cfg_hit = paddr[PaddrW-1:2] == RegJumpLimit;
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? PdataW'(jump_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_limit_q <= JumpLimitReset;
    end else if (cfg_wr) begin
      jump_limit_q <= pwdata[LimitW-1:0];
    end
  end

  dtsvf_store u_store (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (sample_cnt_q),
    .wtemp_i   (in_i.digital_temp),
    .whum_i    (in_i.digital_humidity),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rtemp_a_o (rtemp_a),
    .rhum_a_o  (rhum_a),
    .rtemp_b_o (rtemp_b)
  );

  dtsvf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .sum_i   (code_sum_q),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  dtsvf_vote u_vote (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (vote_start),
    .temp_a_i (rtemp_a),
    .hum_a_i  (rhum_a),
    .temp_b_i (rtemp_b),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .res_o    (vote_res)
  );

  // end-of-batch decision
  assign missed   = valid_cnt_q != CountW'(Samples);
  assign majority = vote_res.best_n > CountW'(Samples / 2);
  assign diff     = (TempW + 1)'(last_temp_q) - (TempW + 1)'(vote_res.temp);
  assign abs_diff = diff[TempW] ? (TempW + 1)'(-diff) : (TempW + 1)'(diff);
  assign jump     = have_acc_q && (abs_diff >= (TempW + 1)'(jump_limit_q));

  always_comb begin
    if (missed) begin
      cause = CauseMissed;
    end else if (!majority) begin
      cause = CauseNoMajority;
    end else if (jump) begin
      cause = CauseJump;
    end else begin
      cause = CauseOk;
    end
  end

  assign new_temp = (cause == CauseOk) ? vote_res.temp : last_temp_q;
  assign new_hum  = (cause == CauseOk) ? vote_res.hum : last_hum_q;
  // floor of the mean is an arithmetic shift of the sum
  assign fuse_sum = $signed((TempW + 1)'(quot)) + (TempW + 1)'(vote_res.temp);
  assign fused    = (cause == CauseOk) ? fuse_sum[TempW:1] : $signed(TempW'(quot));

  assign in_ready    = state_q == StCollect;
  assign in_acc      = in_i.valid && in_ready;
  assign last_sample = sample_cnt_q == SampleW'(Samples - 1);

  always_comb begin
    state_d      = state_q;
    sample_cnt_d = sample_cnt_q;
    valid_cnt_d  = valid_cnt_q;
    code_sum_d   = code_sum_q;
    div_go_d     = 1'b0;
    vote_start   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      StCollect: begin
        if (in_acc) begin
          code_sum_d  = code_sum_q + SumW'(in_i.analog_code);
          valid_cnt_d = valid_cnt_q + CountW'(in_i.digital_valid);
          if (last_sample) begin
            sample_cnt_d = '0;
            div_go_d     = 1'b1;
            state_d      = StDivide;
          end else begin
            sample_cnt_d = sample_cnt_q + SampleW'(1);
          end
        end
      end
      StDivide: begin
        if (div_stat.done) begin
          if (missed) begin
            state_d = StFinish;
          end else begin
            vote_start = 1'b1;
            state_d    = StScan;
          end
        end
      end
      StScan: begin
        if (vote_res.done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          code_sum_d  = '0;
          valid_cnt_d = '0;
          state_d     = StCollect;
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StCollect;
      sample_cnt_q <= '0;
      valid_cnt_q  <= '0;
      code_sum_q   <= '0;
      div_go_q     <= 1'b0;
      last_temp_q  <= '0;
      last_hum_q   <= '0;
      have_acc_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sample_cnt_q <= sample_cnt_d;
      valid_cnt_q  <= valid_cnt_d;
      code_sum_q   <= code_sum_d;
      div_go_q     <= div_go_d;
      if (out_load) begin
        last_temp_q <= new_temp;
        last_hum_q  <= new_hum;
        if (cause == CauseOk) begin
          have_acc_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fused_q    <= fused;
      out_atemp_q    <= quot;
      out_acc_temp_q <= new_temp;
      out_acc_hum_q  <= new_hum;
      out_down_q     <= cause != CauseOk;
      out_cause_q    <= cause;
    end
  end

  assign in_i.ready              = in_ready;
  assign out_o.valid             = out_valid_q;
  assign out_o.fused_temp        = out_fused_q;
  assign out_o.analog_temp       = out_atemp_q;
  assign out_o.accepted_temp     = out_acc_temp_q;
  assign out_o.accepted_humidity = out_acc_hum_q;
  assign out_o.digital_down      = out_down_q;
  assign out_o.fault_cause       = out_cause_q;

  `DTSVF_ASSERT_NEXT(a_last_item_stalls, in_acc && last_sample, !in_i.ready, "input still open after last item")
  `DTSVF_ASSERT_NOW(a_result_from_finish, $rose(out_valid_q), $past(state_q == StFinish), "result loaded outside finish")
  `DTSVF_ASSERT_NOW(a_scan_only_full_batch, state_q == StScan, !missed && !div_stat.busy, "vote scan on partial batch")
  `DTSVF_ASSERT_NEXT(a_reject_keeps_value, out_load && (cause != CauseOk), last_temp_q == $past(last_temp_q), "rejected batch changed accepted value")

endmodule

### rtl/dtsvf_store.sv
`timescale 1ns / 1ps
// sample store: digital temperature and humidity per sample slot
// one write port, two registered read ports; depends on dtsvf_pkg
module dtsvf_store import dtsvf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [SampleW-1:0]      waddr_i,
  input  logic signed [TempW-1:0] wtemp_i,
  input  logic [HumW-1:0]         whum_i,
  input  logic [SampleW-1:0]      raddr_a_i,
  input  logic [SampleW-1:0]      raddr_b_i,
  output logic signed [TempW-1:0] rtemp_a_o,
  output logic [HumW-1:0]         rhum_a_o,
  output logic signed [TempW-1:0] rtemp_b_o
);

  logic signed [TempW-1:0] temp_mem [Samples];
  logic [HumW-1:0]         hum_mem  [Samples];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      temp_mem[waddr_i] <= wtemp_i;
      hum_mem[waddr_i]  <= whum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rtemp_a_o <= temp_mem[raddr_a_i];
    rhum_a_o  <= hum_mem[raddr_a_i];
    rtemp_b_o <= temp_mem[raddr_b_i];
  end

endmodule

### rtl/dtsvf_div.sv
`timescale 1ns / 1ps
// calibration divider: scales the code sum into a register, then divides by a constant
// with a shift and a reciprocal multiply into the quotient register; depends on dtsvf_pkg
module dtsvf_div import dtsvf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SumW-1:0]   sum_i,
  output div_stat_t         stat_o,
  output logic [QuotW-1:0]  quot_o
);

  logic              run_q;
  logic              done_q;
  logic [NumW-1:0]   num_q, num_d;
  logic [QuotW-1:0]  quot_q, quot_d;

  logic [SumW+DivKW-1:0]     prod;
  logic [NumW-1:0]           num;
  logic [ScaledW-1:0]        scaled;
  logic [ScaledW+RecipW-1:0] recip_prod;

  assign prod       = (SumW + DivKW)'(sum_i) * (SumW + DivKW)'(DivNumK);
  assign num        = NumW'(prod) + NumW'(DivNumC);
  assign num_d      = start_i ? num : num_q;
  assign scaled     = num_q[NumW-1:DivPow];
  assign recip_prod = (ScaledW + RecipW)'(scaled) * (ScaledW + RecipW)'(Recip);
  assign quot_d     = run_q ? QuotW'(recip_prod >> RecipShift) : quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= start_i;
      done_q <= run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

### rtl/dtsvf_vote.sv
`timescale 1ns / 1ps
// majority scan: one stored pair compared per cycle, earliest mode wins ties
// drives the store read ports; depends on dtsvf_pkg
module dtsvf_vote import dtsvf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [TempW-1:0] temp_a_i,
  input  logic [HumW-1:0]         hum_a_i,
  input  logic signed [TempW-1:0] temp_b_i,
  output logic [SampleW-1:0]      addr_a_o,
  output logic [SampleW-1:0]      addr_b_o,
  output vote_res_t               res_o
);

  logic                    run_q, run_d;
  logic [SampleW-1:0]      i_q, i_d;
  logic [SampleW-1:0]      j_q, j_d;
  logic                    pend_q, pend_jlast_q, pend_end_q;
  logic [CountW-1:0]       n_q, n_d;
  logic [CountW-1:0]       best_n_q, best_n_d;
  logic                    done_q, done_d;
  logic signed [TempW-1:0] best_temp_q;
  logic [HumW-1:0]         best_hum_q;

  logic              i_last, j_last;
  logic [CountW-1:0] n_cur;
  logic              better;

  assign i_last = i_q == SampleW'(Samples - 1);
  assign j_last = j_q == SampleW'(Samples - 1);
  assign n_cur  = n_q + CountW'(temp_a_i == temp_b_i);
  // read data arrives in the cycle after its addresses are driven
  assign better = pend_q && pend_jlast_q && (n_cur > best_n_q);

  always_comb begin
    run_d    = run_q;
    i_d      = i_q;
    j_d      = j_q;
    n_d      = n_q;
    best_n_d = best_n_q;
    done_d   = 1'b0;
    if (start_i) begin
      run_d    = 1'b1;
      i_d      = '0;
      j_d      = '0;
      n_d      = '0;
      best_n_d = '0;
    end else begin
      if (run_q) begin
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d   = '0;
            run_d = 1'b0;
          end else begin
            i_d = i_q + SampleW'(1);
          end
        end else begin
          j_d = j_q + SampleW'(1);
        end
      end
      if (pend_q) begin
        if (pend_jlast_q) begin
          n_d    = '0;
          done_d = pend_end_q;
          if (better) begin
            best_n_d = n_cur;
          end
        end else begin
          n_d = n_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      pend_q       <= 1'b0;
      pend_jlast_q <= 1'b0;
      pend_end_q   <= 1'b0;
      n_q          <= '0;
      best_n_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      run_q        <= run_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_q       <= run_q && !start_i;
      pend_jlast_q <= j_last;
      pend_end_q   <= j_last && i_last;
      n_q          <= n_d;
      best_n_q     <= best_n_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_temp_q <= temp_a_i;
      best_hum_q  <= hum_a_i;
    end
  end

  assign addr_a_o     = i_q;
  assign addr_b_o     = j_q;
  assign res_o.done   = done_q;
  assign res_o.best_n = best_n_q;
  assign res_o.temp   = best_temp_q;
  assign res_o.hum    = best_hum_q;

endmodule

### bench/dtsvf_fusion_checker.sv
`timescale 1ns / 1ps
// checker for the dual sensor fusion core: folds accepted sample items into a batch model,
// predicts each fused reading and compares it with the result channel; snoops the apb port
// depends on dtsvf_pkg, dtsvf_in_if, dtsvf_out_if
module dtsvf_fusion_checker import dtsvf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtsvf_in_if               smp_if,
  dtsvf_out_if              res_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic [PdataW-1:0] prdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_count_o,
  output int                reading_count_o
);

  typedef struct packed {
    logic signed [TempW-1:0] fused;
    logic [AtempW-1:0]       atemp;
    logic signed [TempW-1:0] acc_temp;
    logic [HumW-1:0]         acc_hum;
    logic                    down;
    cause_e                  cause;
  } reading_t;

  reading_t                readings_q[$];
  logic [LimitW-1:0]       jump_limit;
  logic [SumW-1:0]         code_sum;
  logic [CountW-1:0]       sample_cnt;
  logic [CountW-1:0]       valid_cnt;
  logic signed [TempW-1:0] temp_store[Samples];
  logic [HumW-1:0]         hum_store[Samples];
  logic signed [TempW-1:0] last_temp;
  logic [HumW-1:0]         last_hum;
  logic                    have_acc;
  int                      fail_cnt = 0;
  int                      reading_cnt = 0;

  // mean code to tenths of a degree, rounded half up, in exact integer form
  function automatic logic [AtempW-1:0] code_sum_to_tenths(input logic [SumW-1:0] s);
    longint unsigned num;
    longint unsigned den;
    num = 64'd500000 * s + 64'd128716800 * Samples;
    den = 64'd1282048 * Samples;
    return AtempW'((2 * num + den) / (2 * den));
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_cnt++;
    end
  endtask

  task automatic fold_sample(input logic [CodeW-1:0] code, input logic signed [TempW-1:0] t,
                             input logic [HumW-1:0] h, input logic v);
    int       n;
    int       best_n;
    int       best_i;
    int       delta;
    reading_t r;
    code_sum += code;
    temp_store[sample_cnt[SampleW-1:0]] = t;
    hum_store[sample_cnt[SampleW-1:0]] = h;
    if (v) valid_cnt++;
    sample_cnt++;
    if (sample_cnt < Samples) return;

    r.atemp = code_sum_to_tenths(code_sum);
    r.cause = CauseOk;
    if (valid_cnt != Samples) begin
      r.cause = CauseMissed;
    end else begin
      best_n = 0;
      best_i = 0;
      // strict greater keeps the earliest entry on ties
      for (int i = 0; i < Samples; i++) begin
        n = 0;
        for (int j = 0; j < Samples; j++)
          if (temp_store[j] == temp_store[i]) n++;
        if (n > best_n) begin
          best_n = n;
          best_i = i;
        end
      end
      if (best_n <= Samples / 2) begin
        r.cause = CauseNoMajority;
      end else begin
        delta = int'(last_temp) - int'(temp_store[best_i]);
        if (delta < 0) delta = -delta;
        if (have_acc && delta >= int'(jump_limit)) begin
          r.cause = CauseJump;
        end else begin
          last_temp = temp_store[best_i];
          last_hum  = hum_store[best_i];
          have_acc  = 1'b1;
        end
      end
    end
    r.acc_temp = last_temp;
    r.acc_hum  = last_hum;
    r.down     = (r.cause != CauseOk);
    // arithmetic shift gives the floor of the mean for negative sums too
    r.fused    = r.down ? TempW'(r.atemp)
                        : TempW'((int'({1'b0, r.atemp}) + int'(last_temp)) >>> 1);
    readings_q.push_back(r);
    code_sum   = '0;
    sample_cnt = '0;
    valid_cnt  = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      jump_limit = JumpLimitReset;
      code_sum   = '0;
      sample_cnt = '0;
      valid_cnt  = '0;
      last_temp  = '0;
      last_hum   = '0;
      have_acc   = 1'b0;
      readings_q.delete();
    end else begin
      if (smp_if.valid && smp_if.ready)
        fold_sample(smp_if.analog_code, smp_if.digital_temp, smp_if.digital_humidity,
                    smp_if.digital_valid);
      if (res_if.valid && res_if.ready) begin
        reading_cnt++;
        if (readings_q.size() == 0) begin
          $display("%0t: fused reading with none expected, actual fused_temp %0d cause %0d",
                   $time, res_if.fused_temp, res_if.fault_cause);
          fail_cnt++;
        end else begin
          exp_r = readings_q.pop_front();
          check_field("fused_temp", int'(exp_r.fused), int'(res_if.fused_temp));
          check_field("analog_temp", int'(exp_r.atemp), int'(res_if.analog_temp));
          check_field("accepted_temp", int'(exp_r.acc_temp), int'(res_if.accepted_temp));
          check_field("accepted_humidity", int'(exp_r.acc_hum),
                      int'(res_if.accepted_humidity));
          check_field("digital_down", int'(exp_r.down), int'(res_if.digital_down));
          check_field("fault_cause", int'(exp_r.cause), int'(res_if.fault_cause));
        end
      end
      if (psel && penable && pready && paddr[PaddrW-1:2] == RegJumpLimit) begin
        if (pwrite) jump_limit = pwdata[LimitW-1:0];
        else check_field("jump_limit readback", int'(jump_limit), int'(prdata));
      end
    end
    fail_count_o    <= fail_cnt;
    pending_count_o <= readings_q.size();
    reading_count_o <= reading_cnt;
  end

endmodule

### bench/tb_dual_temp_sensor_vote_fusion_core.sv
`timescale 1ns / 1ps
// testbench top for the dual sensor fusion core: clock, reset, sample and apb stimulus, verdict
// depends on dtsvf_pkg, dtsvf_in_if, dtsvf_out_if, dtsvf_fusion_checker and the core
module tb_dual_temp_sensor_vote_fusion_core;
  import dtsvf_pkg::*;

  localparam int PhaseCount      = 8;
  localparam int BatchesPerPhase = 12;
  localparam int SettleCycles    = 120;
  localparam int CycleLimit      = 300000;
  localparam logic [PaddrW-1:0] JumpLimitAddr = {RegJumpLimit, 2'b00};

  typedef enum logic [1:0] {RxFree, RxJitter, RxStall} rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata, prdata;

  int       mismatch_cnt, readings_due, readings_seen;
  int       cycle_cnt = 0;
  int       item_cnt = 0;
  int       batch_cnt = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       temp_track = 250;
  rx_mode_e rx_mode = RxFree;
  int       rx_left = 0;

  logic [CodeW-1:0]        b_code[Samples];
  logic signed [TempW-1:0] b_temp[Samples];
  logic [HumW-1:0]         b_hum[Samples];
  logic                    b_vld[Samples];

  dtsvf_in_if  smp_ch();
  dtsvf_out_if fused_ch();

  dual_temp_sensor_vote_fusion_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (smp_ch),
    .out_o   (fused_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dtsvf_fusion_checker u_fusion_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .smp_if          (smp_ch),
    .res_if          (fused_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (mismatch_cnt),
    .pending_count_o (readings_due),
    .reading_count_o (readings_seen)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d fused readings still due", cycle_cnt,
               readings_due);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: segments of free flow, per-cycle jitter and long stalls
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RxStall) ? $urandom_range(1, 40) : $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_mode)
      RxFree:   fused_ch.ready <= 1'b1;
      RxJitter: fused_ch.ready <= 1'($urandom_range(0, 1));
      default:  fused_ch.ready <= 1'b0;
    endcase
  end

  // called at a falling edge; returns at a falling edge with the bus idle
  task automatic reg_access(input logic wr, input logic [PaddrW-1:0] a,
                            input logic [PdataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_jump_limit(input logic [LimitW-1:0] lim);
    reg_access(1'b1, JumpLimitAddr, PdataW'(lim));
    reg_access(1'b0, JumpLimitAddr, '0);
  endtask

  // within a burst valid stays high after an item is taken, so the next item follows without a bubble
  task automatic send_sample(input int k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        smp_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    smp_ch.valid            <= 1'b1;
    smp_ch.analog_code      <= b_code[k];
    smp_ch.digital_temp     <= b_temp[k];
    smp_ch.digital_humidity <= b_hum[k];
    smp_ch.digital_valid    <= b_vld[k];
    do @(posedge clk_i); while (!smp_ch.ready);
    @(negedge clk_i);
    burst_left--;
    item_cnt++;
  endtask

  task automatic send_batch();
    for (int k = 0; k < Samples; k++) send_sample(k);
    batch_cnt++;
  endtask

  // block is idle once every reading is out and the last batch's work has settled
  task automatic wait_idle();
    smp_ch.valid <= 1'b0;
    while (readings_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic signed [TempW-1:0] clamp_temp(input int t);
    if (t < -400) return -TempW'(400);
    if (t > 1250) return TempW'(1250);
    return TempW'(t);
  endfunction

  // mostly well-formed batches with a majority near the previous value, plus ties and noise
  task automatic fill_random_batch();
    int                      pos[Samples];
    int                      tmp, sel, maj_n, span, code_base;
    bit                      alt_same;
    logic signed [TempW-1:0] base, alt;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      case ($urandom_range(0, 2))
        0:       span = 3;
        1:       span = 40;
        default: span = 300;
      endcase
      base = clamp_temp(temp_track + int'($urandom_range(0, 2 * span)) - span);
    end else if (sel < 8) begin
      base = TempW'(int'($urandom_range(0, 1650)) - 400);
    end else begin
      base = TempW'($urandom_range(0, 4095));
    end
    temp_track = int'(base);

    sel = $urandom_range(0, 9);
    if (sel < 6)      maj_n = $urandom_range(Samples / 2 + 1, Samples);
    else if (sel < 8) maj_n = $urandom_range(Samples / 2 - 1, Samples / 2);
    else              maj_n = $urandom_range(0, 2);

    for (int k = 0; k < Samples; k++) pos[k] = k;
    for (int k = Samples - 1; k > 0; k--) begin
      sel = $urandom_range(0, k);
      tmp = pos[k];
      pos[k] = pos[sel];
      pos[sel] = tmp;
    end

    // one shared runner-up value gives ties at half the batch
    alt_same = $urandom_range(0, 1);
    alt = base + TempW'($urandom_range(1, 9));
    for (int k = 0; k < Samples; k++) begin
      if (k < maj_n) b_temp[pos[k]] = base;
      else if (alt_same) b_temp[pos[k]] = alt;
      else if ($urandom_range(0, 3) == 0) b_temp[pos[k]] = TempW'($urandom_range(0, 4095));
      else b_temp[pos[k]] = TempW'(int'($urandom_range(0, 1650)) - 400);
    end

    code_base = $urandom_range(0, 1023);
    sel = $urandom_range(0, 2);
    for (int k = 0; k < Samples; k++) begin
      if (sel == 0) b_code[k] = CodeW'($urandom_range(0, 1023));
      else b_code[k] = CodeW'((code_base + int'($urandom_range(0, 30)) > 1023) ? 1023
                              : code_base + int'($urandom_range(0, 30)));
      b_hum[k] = ($urandom_range(0, 4) == 0) ? HumW'($urandom_range(0, 1023))
                                             : HumW'($urandom_range(0, 1000));
      b_vld[k] = 1'b1;
    end
    if ($urandom_range(0, 6) == 0) begin
      for (int k = 0; k < Samples; k++) b_vld[k] = 1'($urandom_range(0, 1));
      b_vld[$urandom_range(0, Samples - 1)] = 1'b0;
    end
  endtask

  initial begin
    logic [LimitW-1:0] lim;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp_ch.valid = 1'b0;
    smp_ch.analog_code = '0;
    smp_ch.digital_temp = '0;
    smp_ch.digital_humidity = '0;
    smp_ch.digital_valid = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset value of the jump limit reads back first
    reg_access(1'b0, JumpLimitAddr, '0);

    // first acceptance, majority not at index 0, values beyond the sensor range
    b_temp = '{-TempW'(2048), 1250, 2047, 1250, -TempW'(400), 1250, 1250, 1250};
    b_hum  = '{0, 1023, 1000, 512, 341, 682, 1, 999};
    for (int k = 0; k < Samples; k++) begin
      b_code[k] = '0;
      b_vld[k]  = 1'b1;
    end
    send_batch();

    // missed sample outranks a split vote and a large jump
    for (int k = 0; k < Samples; k++) begin
      b_code[k] = CodeW'(1023);
      b_temp[k] = k[0] ? TempW'(1250) : -TempW'(400);
      b_hum[k]  = HumW'(k * 100);
      b_vld[k]  = (k != 5);
    end
    send_batch();

    // four against four: no majority outranks the jump check
    for (int k = 0; k < Samples; k++) begin
      b_code[k] = k[0] ? CodeW'(1023) : CodeW'(0);
      b_temp[k] = (k < Samples / 2) ? TempW'(2047) : -TempW'(400);
      b_hum[k]  = HumW'(1000 - k);
      b_vld[k]  = 1'b1;
    end
    send_batch();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       lim = '0;
        1:       lim = LimitW'(1650);
        2:       lim = '1;
        3:       lim = JumpLimitReset;
        default: lim = LimitW'($urandom_range(0, 1650));
      endcase
      gaps_on = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      wait_idle();
      set_jump_limit(lim);
      for (int b = 0; b < BatchesPerPhase; b++) begin
        fill_random_batch();
        send_batch();
      end
    end

    wait_idle();
    $display("sent %0d sample items in %0d batches, checked %0d fused readings",
             item_cnt, batch_cnt, readings_seen);
    $display("jump limit covered reset value, 0, 1650, all ones and %0d random settings",
             PhaseCount - 4);
    if (mismatch_cnt == 0 && readings_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dtsvf_pkg.sv
rtl/dtsvf_in_if.sv
rtl/dtsvf_out_if.sv
rtl/dtsvf_store.sv
rtl/dtsvf_div.sv
rtl/dtsvf_vote.sv
rtl/dual_temp_sensor_vote_fusion_core.sv
bench/dtsvf_fusion_checker.sv
bench/tb_dual_temp_sensor_vote_fusion_core.sv
